@@ src/slot_allocator_with_reuse_delay_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SLOT_ALLOCATOR_WITH_REUSE_DELAY_ASSERT_SVH
`define SLOT_ALLOCATOR_WITH_REUSE_DELAY_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define SARD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SARD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SARD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sard_pkg.sv @@
// Package for the slot allocator: sizes, codes, state and handshake types.
// No dependencies; used by every module of the block.
package sard_pkg;

   localparam int MAX_ENTITIES = 1024;
   localparam int SLOT_W       = 10;
   localparam int MARK_W       = 11;
   localparam int TIME_W       = 32;
   localparam int ENTRY_W      = TIME_W + 1;
   localparam int CS_W         = 8;
   localparam int CFG_W        = 16;
   localparam int CSR_IDX_W    = 2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_SLOTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_GRACE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_DELAY   = 2'd2;

   localparam logic [CS_W-1:0]  CLIENT_SLOTS_RST  = 8'd1;
   localparam logic [CFG_W-1:0] STARTUP_GRACE_RST = 16'd2000;
   localparam logic [CFG_W-1:0] REUSE_DELAY_RST   = 16'd500;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BEYOND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FREE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic free_commit;
      logic alloc_commit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic done;
   } stat_type;

endpackage

@@ src/sard_ram.sv @@
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module sard_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/sard_ctrl.sv @@
// Controller state machine for the slot allocator: sequences free and scan.
// Depends on sard_pkg and the assertion macro header.
`include "slot_allocator_with_reuse_delay_assert.svh"

module sard_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  sard_pkg::stat_type stat,
   output sard_pkg::cmd_type  cmd,
   output logic               busy
);
   import sard_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_action == ACT_FREE) ? S_FREE : S_SCAN;
            end
         end
         S_FREE: begin
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (stat.hit || stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_FREE: begin
            cmd.free_commit = 1'b1;
         end
         S_SCAN: begin
            cmd.scan         = 1'b1;
            cmd.alloc_commit = stat.hit || stat.done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   `SARD_ASSERT_NEXT(a_free_one_cycle, clock, reset, state_ff == S_FREE, state_ff == S_IDLE, "free did not finish in one cycle")
   `SARD_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `SARD_ASSERT_IMPL(a_hit_only_scanning, clock, reset, stat.hit, state_ff == S_SCAN, "hit reported outside a scan")

endmodule

@@ src/sard_dp.sv @@
// Datapath for the slot allocator: config registers, mark, scan pointer,
// slot table RAM and result registers. Depends on sard_pkg, sard_ram, macros.
`include "slot_allocator_with_reuse_delay_assert.svh"

module sard_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  sard_pkg::cmd_type                  cmd,
   output sard_pkg::stat_type                 stat,
   input  logic [sard_pkg::SLOT_W-1:0]        req_slot_in,
   input  logic [sard_pkg::TIME_W-1:0]        req_now,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sard_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sard_pkg::CFG_W-1:0]         csr_wdata,
   output logic                               rsp_valid,
   output logic [sard_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_reused
);
   import sard_pkg::*;

   logic [CS_W-1:0]    cs_ff;
   logic [CFG_W-1:0]   grace_ff;
   logic [CFG_W-1:0]   delay_ff;
   logic [MARK_W-1:0]  hw_ff, hw_in;
   logic [SLOT_W-1:0]  slot_in_ff, slot_in_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [MARK_W-1:0]  mark_ff, mark_in;
   logic [MARK_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]  chk_idx_ff, chk_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_reused_ff, rsp_reused_in;

   logic [MARK_W-1:0]  scan_base;
   logic [MARK_W-1:0]  mark_now;
   logic               issue;
   logic               we;
   logic [SLOT_W-1:0]  waddr;
   logic [ENTRY_W-1:0] wdata;
   logic [ENTRY_W-1:0] rdata;
   logic [TIME_W-1:0]  rd_time;
   logic [TIME_W:0]    ready_time;
   logic               reusable;

   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff    <= CLIENT_SLOTS_RST;
         grace_ff <= STARTUP_GRACE_RST;
         delay_ff <= REUSE_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLIENT_SLOTS:  cs_ff    <= csr_wdata[CS_W-1:0];
            CSR_STARTUP_GRACE: grace_ff <= csr_wdata;
            CSR_REUSE_DELAY:   delay_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign scan_base = {{(MARK_W-CS_W){1'b0}}, cs_ff} + MARK_W'(1);
   assign mark_now  = (hw_ff > scan_base) ? hw_ff : scan_base;

   // slot table: free flag on top, free time below
   sard_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTITIES)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rd_idx_ff[SLOT_W-1:0]),
      .rdata (rdata)
   );

   assign rd_time    = rdata[TIME_W-1:0];
   assign ready_time = {1'b0, rd_time} + {{(TIME_W+1-CFG_W){1'b0}}, delay_ff};
   assign reusable   = rdata[TIME_W] &&
                       ((rd_time < {{(TIME_W-CFG_W){1'b0}}, grace_ff}) ||
                        ({1'b0, now_ff} > ready_time));

   assign issue     = rd_idx_ff < mark_ff;
   assign stat.hit  = chk_vld_ff && reusable;
   assign stat.done = !chk_vld_ff && !issue;

   always_comb begin
      hw_in         = hw_ff;
      slot_in_in    = slot_in_ff;
      now_in        = now_ff;
      mark_in       = mark_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_reused_in = rsp_reused_ff;
      we            = 1'b0;
      waddr         = slot_in_ff;
      wdata         = {1'b1, now_ff};

      // latch the request, fix the mark, point the scan at the first slot
      if (cmd.load) begin
         slot_in_in = req_slot_in;
         now_in     = req_now;
         mark_in    = mark_now;
         rd_idx_in  = scan_base;
         chk_vld_in = 1'b0;
      end

      // advance the scan: one read issued, one entry checked per cycle
      if (cmd.scan) begin
         chk_vld_in = issue;
         chk_idx_in = rd_idx_ff[SLOT_W-1:0];
         if (issue) begin
            rd_idx_in = rd_idx_ff + MARK_W'(1);
         end
      end

      if (cmd.free_commit) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = slot_in_ff;
         rsp_reused_in = 1'b0;
         if ({1'b0, slot_in_ff} >= mark_ff) begin
            rsp_status_in = ST_BEYOND;
         end else begin
            rsp_status_in = ST_OK;
            we            = 1'b1;
         end
      end

      // finish the scan: commit the result, take the slot found or grown, drop the read in flight
      if (cmd.alloc_commit) begin
         rsp_valid_in = 1'b1;
         chk_vld_in   = 1'b0;
         wdata        = {1'b0, now_ff};
         if (stat.hit) begin
            we            = 1'b1;
            waddr         = chk_idx_ff;
            rsp_slot_in   = chk_idx_ff;
            rsp_status_in = ST_OK;
            rsp_reused_in = 1'b1;
         end else if (mark_ff >= MARK_W'(MAX_ENTITIES)) begin
            rsp_slot_in   = '0;
            rsp_status_in = ST_FULL;
            rsp_reused_in = 1'b0;
         end else begin
            we            = 1'b1;
            waddr         = mark_ff[SLOT_W-1:0];
            hw_in         = mark_ff + MARK_W'(1);
            rsp_slot_in   = mark_ff[SLOT_W-1:0];
            rsp_status_in = ST_OK;
            rsp_reused_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_in_ff    <= slot_in_in;
      now_ff        <= now_in;
      mark_ff       <= mark_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_reused   = rsp_reused_ff;

   `SARD_ASSERT_ALWAYS(a_hw_in_range, clock, reset, hw_ff <= MARK_W'(MAX_ENTITIES), "high-water mark beyond table")
   `SARD_ASSERT_IMPL(a_hit_in_window, clock, reset, cmd.alloc_commit && stat.hit, ({1'b0, chk_idx_ff} >= scan_base) && ({1'b0, chk_idx_ff} < mark_ff), "reused slot outside scan window")
   `SARD_ASSERT_NEXT(a_one_result_per_commit, clock, reset, cmd.free_commit || cmd.alloc_commit, rsp_valid_ff, "commit produced no result")

endmodule

@@ src/slot_allocator_with_reuse_delay.sv @@
// Top level of the slot allocator with reuse delay.
// Depends on sard_pkg, sard_ctrl, sard_dp (which holds sard_ram).
//
// Usage:
//   Request channel: raise start with req_action, req_slot_in and req_now;
//   the item is taken at an edge where start is high and busy is low.
//   Busy stays high until the item's result is committed.
//   Result channel: rsp_valid is high for exactly one cycle with
//   rsp_slot_out, rsp_status and rsp_reused; the receiver cannot stall it.
//   Configuration: csr_valid/csr_ready with csr_index and csr_wdata; ready
//   is always high. Write only while busy is low and no result is pending.
// Sequencing:
//   A free is busy in S_FREE; its result shows in the first cycle busy is low.
//   An allocation checks one slot per cycle through the slot table RAM's read
//   port (registered read), from client_slots+1 up to the mark, and stops at the
//   first reusable slot. The result shows in the first cycle busy is low, and
//   a new item may be taken in that cycle.
// Reset:
//   Synchronous, active high. Config returns to 1 / 2000 / 500 ms, the
//   high-water mark to zero. The slot table needs no clearing: every entry
//   scanned is written by growth first, unless client_slots is lowered.
module slot_allocator_with_reuse_delay (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [sard_pkg::SLOT_W-1:0]        req_slot_in,
   input  logic [sard_pkg::TIME_W-1:0]        req_now,
   output logic                               rsp_valid,
   output logic [sard_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_reused,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sard_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sard_pkg::CFG_W-1:0]         csr_wdata
);
   import sard_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the item: decode, scan or free, commit
   sard_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // hold config, mark and slot table; drive the result registers
   sard_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_slot_in  (req_slot_in),
      .req_now      (req_now),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_slot_out (rsp_slot_out),
      .rsp_status   (rsp_status),
      .rsp_reused   (rsp_reused)
   );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for slot_allocator_with_reuse_delay: a directed table and then
// randomized phases, each with its own settings, checked against a slot-table predictor.
// Depends on sard_pkg and the slot_allocator_with_reuse_delay RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sard_pkg::*;

   // Worst item: a scan of the whole table plus the longest request gap.
   localparam int ITEM_CAP    = 1800;
   localparam int CYCLE_LIMIT = 4 * (ITEM_CAP * (MAX_ENTITIES + 24) + 20000);

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
      logic              reused;
   } outcome_t;

   // One directed item; the expected fields count only where typed is set.
   typedef struct packed {
      logic              typed;
      logic              action;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now;
      logic [SLOT_W-1:0] exp_slot;
      status_type        exp_status;
      logic              exp_reused;
   } step_row_t;

   // Run at the reset settings: 1 client slot, 2000 ms grace, 500 ms delay.
   localparam int DIRECTED_ROWS = 21;
   localparam step_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
      '{1'b1, ACT_ALLOC, 10'd0,    32'd0,          10'd2,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'd10,         10'd3,    ST_OK,     1'b0},
      '{1'b0, ACT_ALLOC, 10'd0,    32'd20,         10'd0,    ST_OK,     1'b0},
      '{1'b0, ACT_FREE,  10'd3,    32'd100,        10'd0,    ST_OK,     1'b0},
      // freed inside the grace time: reusable at once
      '{1'b1, ACT_ALLOC, 10'd0,    32'd101,        10'd3,    ST_OK,     1'b1},
      '{1'b1, ACT_FREE,  10'd1023, 32'd0,          10'd1023, ST_BEYOND, 1'b0},
      '{1'b1, ACT_FREE,  10'd5,    32'd0,          10'd5,    ST_BEYOND, 1'b0},
      // reserved slots may be freed; they are never scanned
      '{1'b1, ACT_FREE,  10'd1,    32'hFFFF_FFFF,  10'd1,    ST_OK,     1'b0},
      '{1'b1, ACT_FREE,  10'd0,    32'd0,          10'd0,    ST_OK,     1'b0},
      '{1'b0, ACT_FREE,  10'd4,    32'd3000,       10'd0,    ST_OK,     1'b0},
      // exactly the delay after the free is not enough, one more ms is
      '{1'b1, ACT_ALLOC, 10'd0,    32'd3500,       10'd5,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'd3501,       10'd4,    ST_OK,     1'b1},
      // free stamp near the top of time: stamp plus delay must not wrap
      '{1'b0, ACT_FREE,  10'd2,    32'hFFFF_FF00,  10'd0,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'hFFFF_FFFF,  10'd6,    ST_OK,     1'b0},
      '{1'b0, ACT_ALLOC, 10'd0,    32'd0,          10'd0,    ST_OK,     1'b0},
      // grace edge: 1999 is inside, 2000 is not
      '{1'b0, ACT_FREE,  10'd7,    32'd1999,       10'd0,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'd0,          10'd7,    ST_OK,     1'b1},
      '{1'b0, ACT_FREE,  10'd6,    32'd2000,       10'd0,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'd2500,       10'd8,    ST_OK,     1'b0},
      '{1'b1, ACT_ALLOC, 10'd0,    32'd2501,       10'd6,    ST_OK,     1'b1},
      '{1'b0, ACT_ALLOC, 10'd1023, 32'd2502,       10'd0,    ST_OK,     1'b0}
   };

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 busy;
   logic                 req_action  = ACT_ALLOC;
   logic [SLOT_W-1:0]    req_slot_in = '0;
   logic [TIME_W-1:0]    req_now     = '0;
   logic                 rsp_valid;
   logic [SLOT_W-1:0]    rsp_slot_out;
   logic [1:0]           rsp_status;
   logic                 rsp_reused;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_CLIENT_SLOTS;
   logic [CFG_W-1:0]     csr_wdata   = '0;

   // Predictor copy of the settings and the slot table.
   bit [CS_W-1:0]   cfg_clients = CLIENT_SLOTS_RST;
   bit [CFG_W-1:0]  cfg_grace   = STARTUP_GRACE_RST;
   bit [CFG_W-1:0]  cfg_delay   = REUSE_DELAY_RST;
   bit              is_free  [MAX_ENTITIES];
   bit [TIME_W-1:0] freed_at [MAX_ENTITIES];
   bit              touched  [MAX_ENTITIES];   // slot written by growth or a free
   int              top_mark = 0;

   outcome_t        pending_outcomes [$];
   bit [TIME_W-1:0] ms_clock = '0;
   int              fulls_seen = 0;
   int              mismatches = 0;
   int              cycles = 0;

   slot_allocator_with_reuse_delay dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_slot_in  (req_slot_in),
      .req_now      (req_now),
      .rsp_valid    (rsp_valid),
      .rsp_slot_out (rsp_slot_out),
      .rsp_status   (rsp_status),
      .rsp_reused   (rsp_reused),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // The mark never goes below client_slots + 1 and grows from there.
   function automatic int mark_now();
      int floor_mark;
      floor_mark = int'(cfg_clients) + 1;
      return (top_mark > floor_mark) ? top_mark : floor_mark;
   endfunction

   // Free, and either freed inside the grace time or quarantined long enough.
   // Take the sum on 33 bits so a late stamp never wraps past now.
   function automatic bit reusable(input int idx, input bit [TIME_W-1:0] now);
      bit [TIME_W:0] ready;
      ready = {1'b0, freed_at[idx]} + {17'd0, cfg_delay};
      return is_free[idx] && (freed_at[idx] < cfg_grace || {1'b0, now} > ready);
   endfunction

   // Advance the slot table by one item and return the result it should give.
   function automatic outcome_t apply_request(input logic act, input logic [SLOT_W-1:0] slot,
                                              input logic [TIME_W-1:0] now);
      outcome_t res;
      int mark;
      int i;
      mark       = mark_now();
      res.slot   = '0;
      res.status = ST_OK;
      res.reused = 1'b0;
      if (act == ACT_FREE) begin
         res.slot = slot;
         if (int'(slot) >= mark) begin
            res.status = ST_BEYOND;
         end else begin
            is_free[slot]  = 1'b1;
            freed_at[slot] = now;
            touched[slot]  = 1'b1;
         end
      end else begin
         i = int'(cfg_clients) + 1;
         while (i < mark && i < MAX_ENTITIES && !reusable(i, now))
            i++;
         if (i < mark && i < MAX_ENTITIES) begin
            is_free[i] = 1'b0;
            res.slot   = SLOT_W'(i);
            res.reused = 1'b1;
         end else if (mark >= MAX_ENTITIES) begin
            res.status = ST_FULL;
            fulls_seen++;
         end else begin
            is_free[mark] = 1'b0;
            touched[mark] = 1'b1;
            res.slot      = SLOT_W'(mark);
            top_mark      = mark + 1;
         end
      end
      return res;
   endfunction

   // Lowering client_slots must not expose a slot below the mark that was never
   // written, since the table holds no defined value there.
   function automatic bit clients_safe(input bit [CS_W-1:0] clients);
      int i;
      for (i = int'(clients) + 1; i < top_mark; i++)
         if (!touched[i])
            return 1'b0;
      return 1'b1;
   endfunction

   // Present one item, hold it until taken, then queue what it should produce.
   // Return in the time step of the accepting edge, so the caller either drives
   // the next item right away or drops start.
   task automatic issue(input logic act, input logic [SLOT_W-1:0] slot,
                        input logic [TIME_W-1:0] now, input bit typed, input outcome_t given);
      outcome_t predicted;
      start       <= 1'b1;
      req_action  <= act;
      req_slot_in <= slot;
      req_now     <= now;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_request(act, slot, now);
      pending_outcomes.push_back(typed ? given : predicted);
   endtask

   task automatic pause_requests(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Write all three registers back to back; valid stays high across them.
   task automatic load_settings(input bit [CS_W-1:0] clients, input bit [CFG_W-1:0] grace,
                                input bit [CFG_W-1:0] delay);
      logic [CSR_IDX_W-1:0] regs [3];
      logic [CFG_W-1:0]     vals [3];
      int k;
      regs[0] = CSR_CLIENT_SLOTS;
      regs[1] = CSR_STARTUP_GRACE;
      regs[2] = CSR_REUSE_DELAY;
      // junk in the upper byte of client_slots must be dropped
      vals[0] = {8'($urandom), clients};
      vals[1] = grace;
      vals[2] = delay;
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_wdata <= vals[k];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid   <= 1'b0;
      cfg_clients = clients;
      cfg_grace   = grace;
      cfg_delay   = delay;
   endtask

   // Mostly allocations and frees of slots in use, with reserved frees and
   // stray indexes mixed in. The fill flavor leans hard on allocation and
   // keeps time creeping so quarantined slots stay out of reach.
   task automatic random_item(input bit fill);
      int pick;
      int mark;
      logic act;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now;
      mark = mark_now();
      pick = $urandom_range(0, 99);
      act  = ACT_FREE;
      slot = SLOT_W'($urandom);
      if (pick < (fill ? 90 : 50)) begin
         act = ACT_ALLOC;
      end else if (pick < (fill ? 100 : 80)) begin
         if (mark > int'(cfg_clients) + 1)
            slot = SLOT_W'($urandom_range(int'(cfg_clients) + 1, mark - 1));
      end else if (pick < 88) begin
         slot = SLOT_W'($urandom_range(0, int'(cfg_clients)));
      end

      pick = fill ? 0 : $urandom_range(0, 99);
      now  = ms_clock;
      if (pick < 80) begin
         ms_clock += fill ? $urandom_range(0, 40) : $urandom_range(0, 300);
         now = ms_clock;
      end else if (pick < 86) begin
         ms_clock = $urandom;
         now = ms_clock;
      end else if (pick < 92) begin
         // drop back around the grace time
         ms_clock = $urandom_range(0, 2 * int'(cfg_grace) + 1);
         now = ms_clock;
      end else begin
         // a stale time, possibly earlier than recent free stamps
         now = ms_clock - $urandom_range(0, 600);
      end
      issue(act, slot, now, 1'b0, '0);
   endtask

   // Drain, switch settings while idle, then run random items with gaps.
   task automatic run_phase(input bit [CS_W-1:0] clients, input bit [CFG_W-1:0] grace,
                            input bit [CFG_W-1:0] delay, input int count,
                            input int idle_pct, input bit fill);
      int n;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      if (!clients_safe(clients))
         clients = cfg_clients;
      load_settings(clients, grace, delay);
      n = 0;
      while (fill ? (fulls_seen < 6 && n < 1200) : n < count) begin
         random_item(fill);
         n++;
         if ($urandom_range(0, 99) < idle_pct)
            pause_requests($urandom_range(1, 19));
      end
      start <= 1'b0;
   endtask

   // Results cannot be held off: take each one on the edge that ends its cycle.
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report($sformatf("unexpected result slot %0d status %0d",
                             rsp_slot_out, rsp_status));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_slot_out !== want.slot)
               report($sformatf("slot_out %0d, want %0d", rsp_slot_out, want.slot));
            if (rsp_status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_reused !== want.reused)
               report($sformatf("reused %0d, want %0d", rsp_reused, want.reused));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      outcome_t given;
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, growth, grace and delay edges, stray frees.
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         given.slot   = DIRECTED_STEPS[k].exp_slot;
         given.status = DIRECTED_STEPS[k].exp_status;
         given.reused = DIRECTED_STEPS[k].exp_reused;
         issue(DIRECTED_STEPS[k].action, DIRECTED_STEPS[k].slot, DIRECTED_STEPS[k].now,
               DIRECTED_STEPS[k].typed, given);
      end
      start <= 1'b0;

      // Low extremes first: once the mark passes a gap, client_slots can only rise.
      ms_clock = 32'd5000;
      run_phase(8'd0, 16'd0, 16'd0, 100, 30, 1'b0);
      run_phase(8'($urandom_range(0, 20)), 16'hFFFF, 16'hFFFF, 100, 20, 1'b0);
      run_phase(8'($urandom_range(0, 40)), 16'($urandom), 16'($urandom_range(0, 1000)),
                120, 40, 1'b0);
      // a stretch with no gaps at all
      run_phase(8'($urandom), 16'($urandom), 16'($urandom), 100, 0, 1'b0);
      run_phase(8'd255, STARTUP_GRACE_RST, REUSE_DELAY_RST, 100, 25, 1'b0);
      // Fill the table until it reports full several times; no gaps here.
      run_phase(8'd255, 16'd0, 16'hFFFF, 0, 0, 1'b1);

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      // hold for a full scan to catch a stray result
      repeat (MAX_ENTITIES + 8) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
